FILE: rtl/dtc_pkg.sv
// Shared constants for the decimal int32 token checker.
// Character codes, widths and the signed 32-bit range limits.
// No dependencies.
package dtc_pkg;

	localparam int unsigned CharWidth = 8;
	localparam int unsigned MagWidth  = 32;
	localparam int unsigned ProdWidth = MagWidth + 4;

	localparam logic [CharWidth-1:0] CH_ZERO  = 8'h30;
	localparam logic [CharWidth-1:0] CH_NINE  = 8'h39;
	localparam logic [CharWidth-1:0] CH_MINUS = 8'h2D;

	localparam logic [MagWidth-1:0] MAG_MAX   = 32'hFFFF_FFFF;
	localparam logic [MagWidth-1:0] POS_LIMIT = 32'h7FFF_FFFF;
	localparam logic [MagWidth-1:0] NEG_LIMIT = 32'h8000_0000;

	// Verdict codes on the result channel
	localparam logic VERDICT_UNKNOWN = 1'b0;
	localparam logic VERDICT_NUMBER  = 1'b1;

endpackage

FILE: rtl/decimal_int32_token_check.sv
// Decimal int32 token checker: one character per transfer, one verdict per token.
// Depends on dtc_pkg for character codes and range limits.
//
// Usage:
//   Slave channel (s_axis_*): one token character per transfer in tdata[7:0];
//   tlast marks the token's last character. Tokens hold at least one character.
//   Master channel (m_axis_*): one verdict per token in tdata[0]
//   (1 = number, 0 = unknown); no transfer for the other characters.
//   A token is a number if it is exactly "0", or an optional '-' and one or
//   more digits whose value is nonzero and fits signed 32 bits.
//   Throughput: one character per cycle, unless a final character waits behind
//   a held verdict. The path from the input register to the result register
//   holds one multiply-by-ten-and-add on the 32-bit running magnitude plus the
//   range compare. The last character is held in the input register, then its
//   verdict in the result register.
//   Reset: clears the token state and empties both registers; s_axis_tready
//   is high right after reset.
//   Stall: while the master side holds tready low, the verdict is held, and
//   the block keeps taking characters until a second final character waits
//   in the input register behind the held verdict.
module decimal_int32_token_check (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [dtc_pkg::CharWidth-1:0]    s_axis_tdata,  // [7:0] character
	input  logic                             s_axis_tlast,  // final_char
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [7:0]                       m_axis_tdata   // [0] is_number, [7:1] zero
);
	import dtc_pkg::*;

	// Input register
	logic                 valid_s1;
	logic [CharWidth-1:0] char_s1;
	logic                 last_s1;

	// Token state
	logic                at_start_q;
	logic                negative_q;
	logic                seen_digit_q;
	logic                malformed_q;
	logic                out_of_range_q;
	logic [MagWidth-1:0] magnitude_q;

	// Result register
	logic out_valid_q;
	logic is_number_q;

	// Next-state values
	logic                is_digit;
	logic [3:0]          digit_val;
	logic [ProdWidth-1:0] product;
	logic                negative_n;
	logic                seen_digit_n;
	logic                malformed_n;
	logic                out_of_range_n;
	logic [MagWidth-1:0] magnitude_n;
	logic                single_zero_n;
	logic                verdict;
	logic                advance;
	logic                out_free;

	// Stage 1 moves on unless a verdict has nowhere to go
	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance       = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || advance;

	// Classify the character and run magnitude * 10 + digit
	always_comb begin
		is_digit  = char_s1 inside {[CH_ZERO:CH_NINE]};
		digit_val = 4'(char_s1 - CH_ZERO);
		product   = {1'b0, magnitude_q, 3'b000} + {3'b000, magnitude_q, 1'b0}
		          + ProdWidth'(digit_val);

		negative_n     = negative_q;
		seen_digit_n   = seen_digit_q;
		malformed_n    = malformed_q;
		out_of_range_n = out_of_range_q;
		magnitude_n    = magnitude_q;
		single_zero_n  = at_start_q && (char_s1 == CH_ZERO);

		if (at_start_q && char_s1 == CH_MINUS) begin
			negative_n = 1'b1;
		end else if (is_digit) begin
			seen_digit_n = 1'b1;
			if (product[ProdWidth-1:MagWidth] != '0) begin
				magnitude_n    = MAG_MAX;
				out_of_range_n = 1'b1;
			end else begin
				magnitude_n = product[MagWidth-1:0];
			end
		end else begin
			malformed_n = 1'b1;
		end

		// Verdict from the state after this character
		if (single_zero_n) begin
			verdict = VERDICT_NUMBER;
		end else if (malformed_n || !seen_digit_n || out_of_range_n || magnitude_n == '0) begin
			verdict = VERDICT_UNKNOWN;
		end else if (negative_n) begin
			verdict = (magnitude_n <= NEG_LIMIT) ? VERDICT_NUMBER : VERDICT_UNKNOWN;
		end else begin
			verdict = (magnitude_n <= POS_LIMIT) ? VERDICT_NUMBER : VERDICT_UNKNOWN;
		end
	end

	// Capture each incoming transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// Advance token state; clear it after the final character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q     <= 1'b1;
			negative_q     <= 1'b0;
			seen_digit_q   <= 1'b0;
			malformed_q    <= 1'b0;
			out_of_range_q <= 1'b0;
			magnitude_q    <= '0;
		end else if (advance) begin
			if (last_s1) begin
				at_start_q     <= 1'b1;
				negative_q     <= 1'b0;
				seen_digit_q   <= 1'b0;
				malformed_q    <= 1'b0;
				out_of_range_q <= 1'b0;
				magnitude_q    <= '0;
			end else begin
				at_start_q     <= 1'b0;
				negative_q     <= negative_n;
				seen_digit_q   <= seen_digit_n;
				malformed_q    <= malformed_n;
				out_of_range_q <= out_of_range_n;
				magnitude_q    <= magnitude_n;
			end
		end
	end

	// Hold the verdict until the master side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			is_number_q <= verdict;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, is_number_q};

endmodule

FILE: rtl/dtc_check.sv
// Port-level checker for decimal_int32_token_check, with its bind statement.
// Depends on the top level's port list only.
module dtc_check (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic       s_axis_tlast,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata
);

	// Upper verdict bits stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[7:1] == 7'b0)
		else $error("verdict padding bits not zero");

	// A stalled verdict holds its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled verdict changed");

	// A new verdict follows an earlier final-character transfer
	a_verdict_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |->
			$past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
		else $error("verdict without a final character");

	// Input back-pressure only while a verdict is stalled
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled with output free");

endmodule

bind decimal_int32_token_check dtc_check u_dtc_check (.*);

FILE: dv/tb_decimal_int32_token_check.sv
// Self-checking testbench for decimal_int32_token_check: directed tokens, then random tokens.
// Verdicts, predicted per transfer or typed in, are compared in order at the result channel.
// Depends on dtc_pkg and rtl/decimal_int32_token_check.sv.
`timescale 1ns / 1ps

module tb_decimal_int32_token_check;
	import dtc_pkg::*;

	localparam int ItemTarget  = 1850;
	localparam int StallLimit  = 2000;
	localparam int HoldCycles  = 300;
	localparam int IdlePercent = 24;

	typedef struct {
		string          text;     // token text; empty means a single raw byte
		logic [7:0]     raw;
		logic           typed;    // verdict typed in below instead of predicted
		logic           verdict;
	} dir_row_t;

	typedef struct {
		logic typed;
		logic verdict;
	} token_note_t;

	typedef struct {
		logic                at_start;
		logic                negative;
		logic                seen_digit;
		logic                malformed;
		logic                out_of_range;
		logic                single_zero;
		logic [MagWidth-1:0] magnitude;
	} token_state_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [CharWidth-1:0] s_axis_tdata = '0;     // [7:0] character
	logic                 s_axis_tlast = 1'b0;   // final_char
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [7:0]           m_axis_tdata;          // [0] is_number, [7:1] zero

	token_state_t  tok;
	token_note_t   token_notes[$];
	logic          verdicts_due[$];
	logic [7:0]    pend[$];
	dir_row_t      dir_tab[10];
	longint unsigned bound_vals[7];

	int  n_sent = 0;
	int  n_chars = 0;
	int  n_tokens = 0;
	int  n_number = 0;
	int  n_unknown = 0;
	int  stall_cycles = 0;
	bit  held_off = 1'b0;
	bit  failed = 1'b0;
	logic steady;

	decimal_int32_token_check dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Both sides run without idling over this stretch of the character stream
	assign steady = (n_chars >= 1000) && (n_chars < 1300);

	// Return the token state to its idle value
	function automatic void token_clear();
		tok.at_start     = 1'b1;
		tok.negative     = 1'b0;
		tok.seen_digit   = 1'b0;
		tok.malformed    = 1'b0;
		tok.out_of_range = 1'b0;
		tok.single_zero  = 1'b0;
		tok.magnitude    = '0;
	endfunction

	// Fold one character into the token state; on the final character return 1 with the verdict
	function automatic logic take_char(input logic [7:0] c, input logic fin, output logic verdict);
		logic                 digit;
		logic [MagWidth+3:0]  wide;
		digit   = (c >= CH_ZERO) && (c <= CH_NINE);
		verdict = VERDICT_UNKNOWN;
		if (tok.at_start && c == CH_MINUS) begin
			tok.negative = 1'b1;
		end else if (digit) begin
			wide = {4'd0, tok.magnitude} * 36'd10 + {28'd0, c - CH_ZERO};
			// saturate and flag once the magnitude leaves 32 bits
			if (wide > {4'd0, MAG_MAX}) begin
				tok.magnitude    = MAG_MAX;
				tok.out_of_range = 1'b1;
			end else begin
				tok.magnitude = wide[MagWidth-1:0];
			end
			tok.seen_digit = 1'b1;
		end else begin
			tok.malformed = 1'b1;
		end
		tok.single_zero = tok.at_start && (c == CH_ZERO);
		tok.at_start    = 1'b0;
		if (!fin)
			return 1'b0;
		if (tok.single_zero)
			verdict = VERDICT_NUMBER;
		else if (tok.malformed || !tok.seen_digit || tok.out_of_range || tok.magnitude == '0)
			verdict = VERDICT_UNKNOWN;
		else if (tok.negative)
			verdict = (tok.magnitude <= NEG_LIMIT) ? VERDICT_NUMBER : VERDICT_UNKNOWN;
		else
			verdict = (tok.magnitude <= POS_LIMIT) ? VERDICT_NUMBER : VERDICT_UNKNOWN;
		token_clear();
		return 1'b1;
	endfunction

	// Offer the pending token one character per transfer, with random idle cycles
	task automatic send_token(input logic typed, input logic verdict);
		token_notes.push_back('{typed, verdict});
		for (int i = 0; i < pend.size(); i++) begin
			while (!steady && $urandom_range(99) < IdlePercent) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
			s_axis_tvalid <= 1'b1;
			s_axis_tdata  <= pend[i];
			s_axis_tlast  <= (i == pend.size() - 1);
			n_sent++;
			do @(posedge clk); while (!s_axis_tready);
		end
	endtask

	// Build a random token: mostly signed decimals, some corrupted, some a lone minus, some plain noise
	task automatic build_token();
		longint unsigned val;
		string           digits;
		int              kind;
		int              pos;
		pend.delete();
		kind = $urandom_range(99);
		if (kind < 12) begin
			repeat ($urandom_range(4, 1)) pend.push_back(8'($urandom_range(255)));
		end else if (kind < 15) begin
			pend.push_back(CH_MINUS);
		end else begin
			if ($urandom_range(1))
				pend.push_back(CH_MINUS);
			if ($urandom_range(9) == 0)
				repeat ($urandom_range(3, 1)) pend.push_back(CH_ZERO);
			case ($urandom_range(3))
				0:       val = bound_vals[$urandom_range(6)];
				1:       val = $urandom_range(9);
				2:       val = $urandom();
				default: val = {$urandom(), $urandom()} >> $urandom_range(63);
			endcase
			digits = $sformatf("%0d", val);
			for (int i = 0; i < digits.len(); i++)
				pend.push_back(digits[i]);
			// corrupt one byte of a well-formed token
			if (kind < 27) begin
				pos = $urandom_range(pend.size() - 1);
				pend[pos] = 8'($urandom_range(255));
			end
		end
	endtask

	// Track transfers on both sides: predict on input, compare on output
	always @(posedge clk) begin
		token_note_t note;
		logic        pred;
		logic        want;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			n_chars++;
			if (take_char(s_axis_tdata, s_axis_tlast, pred)) begin
				note = token_notes.pop_front();
				verdicts_due.push_back(note.typed ? note.verdict : pred);
			end
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (m_axis_tdata[0])
				n_number++;
			else
				n_unknown++;
			if (verdicts_due.size() == 0) begin
				$error("is_number: result with none expected, actual %0b", m_axis_tdata[0]);
				failed = 1'b1;
			end else begin
				want = verdicts_due.pop_front();
				if (m_axis_tdata[0] !== want) begin
					$error("is_number: expected %0b, actual %0b", want, m_axis_tdata[0]);
					failed = 1'b1;
				end
			end
		end
	end

	// End the run when no transfer happens for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == StallLimit) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Drive the result ready: random idling, one long hold-off to back up the input
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held_off && n_chars >= 400) begin
				held_off = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
			end
			m_axis_tready <= steady || ($urandom_range(99) >= IdlePercent);
		end
	end

	initial begin
		token_clear();
		bound_vals = '{64'd2147483647, 64'd2147483648, 64'd2147483649, 64'd4294967295,
			64'd4294967296, 64'd429496730, 64'd1};
		dir_tab = '{
			'{"0",          8'h00, 1'b1, VERDICT_NUMBER},
			'{"-",          8'h00, 1'b1, VERDICT_UNKNOWN},
			'{"00",         8'h00, 1'b1, VERDICT_UNKNOWN},
			'{"-0",         8'h00, 1'b1, VERDICT_UNKNOWN},
			'{"",           8'h00, 1'b1, VERDICT_UNKNOWN},
			'{"",           8'hFF, 1'b1, VERDICT_UNKNOWN},
			'{"+7",         8'h00, 1'b1, VERDICT_UNKNOWN},
			'{"5 ",         8'h00, 1'b1, VERDICT_UNKNOWN},
			'{"2147483648", 8'h00, 1'b1, VERDICT_UNKNOWN},
			'{"-42",        8'h00, 1'b0, VERDICT_UNKNOWN}
		};

		// hold reset, release on a rising edge
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed tokens
		foreach (dir_tab[r]) begin
			pend.delete();
			if (dir_tab[r].text.len() == 0)
				pend.push_back(dir_tab[r].raw);
			else
				for (int i = 0; i < dir_tab[r].text.len(); i++)
					pend.push_back(dir_tab[r].text[i]);
			send_token(dir_tab[r].typed, dir_tab[r].verdict);
		end

		// random tokens
		while (n_sent < ItemTarget) begin
			build_token();
			send_token(1'b0, VERDICT_UNKNOWN);
		end
		s_axis_tvalid <= 1'b0;

		// drain outstanding verdicts, then let the pipeline settle
		while (verdicts_due.size() != 0 || token_notes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		n_tokens = n_number + n_unknown;
		$display("Covered %0d tokens over %0d character transfers: %0d numbers, %0d unknown.",
			n_tokens, n_chars, n_number, n_unknown);
		$display("Included a %0d-cycle result hold-off with input back-pressure.", HoldCycles);
		if (!failed) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

FILE: decimal_int32_token_check.f
rtl/dtc_pkg.sv
rtl/decimal_int32_token_check.sv
rtl/dtc_check.sv
dv/tb_decimal_int32_token_check.sv
